// ----- sv/wtss_pkg.sv -----
// ----------------------------------------------------------------------------
// wtss_pkg - shared types, constants and functions
// Configuration and result types, register indexes and the token / candidate
// checks used by the whole-token string search.
// ----------------------------------------------------------------------------
package wtss_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int LINE_MAX    = 4096;
   localparam int POS_W       = 12;                 // positions reported in results
   localparam int CNT_W       = $clog2(LINE_MAX + 1); // line length counter, holds LINE_MAX
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
   localparam int WIN_DEPTH   = PATTERN_MAX + 1;
   localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_HIGH = 3'd1,
      REG_PATTERN_LEN  = 3'd2,
      REG_CASE_FOLD    = 3'd3,
      REG_NONDELIM_0   = 3'd4,
      REG_NONDELIM_1   = 3'd5,
      REG_NONDELIM_2   = 3'd6,
      REG_NONDELIM_3   = 3'd7
   } csr_index_type;

   typedef logic [WIN_DEPTH-1:0][7:0] window_type;

   typedef struct packed {
      logic [PATTERN_MAX-1:0][7:0] pattern;
      logic [LEN_W-1:0]            pattern_len;  // already clamped to 1..PATTERN_MAX
      logic                        case_fold;
      logic [255:0]                nondelim;
   } cfg_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] match_begin;
      logic [POS_W-1:0] match_end;
      logic             offset_error;
   } rsp_type;

   function automatic logic [7:0] fold(input logic [7:0] c, input logic case_fold);
      logic [7:0] r;
      r = c;
      if (case_fold && c >= 8'h61 && c <= 8'h7a)
         r = c - 8'h20;
      return r;
   endfunction

   function automatic logic is_boundary(input logic [7:0] c, input logic [255:0] nondelim);
      logic alnum;
      alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
              (c >= 8'h61 && c <= 8'h7a);
      return !alnum && !nondelim[c];
   endfunction

   // Candidate made of the n bytes just before position endp; window[0] is endp-1.
   function automatic logic cand_ok(input window_type       window,
                                    input logic [CNT_W-1:0] endp,
                                    input logic [POS_W-1:0] start,
                                    input cfg_type          cfg);
      logic             ok;
      logic [CNT_W-1:0] first_pos;
      logic [LEN_W-1:0] idx;
      ok        = endp >= CNT_W'(cfg.pattern_len);
      first_pos = endp - CNT_W'(cfg.pattern_len);
      if (first_pos < CNT_W'(start))
         ok = 1'b0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         idx = cfg.pattern_len - LEN_W'(1) - LEN_W'(j);
         if (LEN_W'(j) < cfg.pattern_len &&
             fold(window[WIN_IDX_W'(idx)], cfg.case_fold) != fold(cfg.pattern[j], cfg.case_fold))
            ok = 1'b0;
      end
      if (first_pos != '0 && !is_boundary(window[WIN_IDX_W'(cfg.pattern_len)], cfg.nondelim))
         ok = 1'b0;
      return ok;
   endfunction

endpackage

// ----- sv/wtss_csr.sv -----
// ----------------------------------------------------------------------------
// wtss_csr - configuration registers
// Holds pattern, length, case folding and non-delimiter masks; presents the
// clamped pattern length to the datapath.
// ----------------------------------------------------------------------------
module wtss_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  wtss_pkg::csr_index_type             csr_index,
   input  logic [wtss_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output wtss_pkg::cfg_type                   cfg
);
   import wtss_pkg::*;

   logic [63:0]      pattern_low_ff;
   logic [63:0]      pattern_high_ff;
   logic [4:0]       pattern_length_ff;
   logic             case_fold_ff;
   logic [3:0][63:0] nondelim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= 5'd1;
         case_fold_ff      <= 1'b0;
         nondelim_ff       <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_PATTERN_LOW:  pattern_low_ff    <= csr_write_data;
            REG_PATTERN_HIGH: pattern_high_ff   <= csr_write_data;
            REG_PATTERN_LEN:  pattern_length_ff <= csr_write_data[4:0];
            REG_CASE_FOLD:    case_fold_ff      <= csr_write_data[0];
            REG_NONDELIM_0:   nondelim_ff[0]    <= csr_write_data;
            REG_NONDELIM_1:   nondelim_ff[1]    <= csr_write_data;
            REG_NONDELIM_2:   nondelim_ff[2]    <= csr_write_data;
            REG_NONDELIM_3:   nondelim_ff[3]    <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.pattern   = {pattern_high_ff, pattern_low_ff};
      cfg.case_fold = case_fold_ff;
      cfg.nondelim  = nondelim_ff;
      // zero counts as one, anything above PATTERN_MAX counts as full length
      if (pattern_length_ff == 5'd0)
         cfg.pattern_len = LEN_W'(1);
      else if (32'(pattern_length_ff) > PATTERN_MAX)
         cfg.pattern_len = LEN_W'(PATTERN_MAX);
      else
         cfg.pattern_len = LEN_W'(pattern_length_ff);
   end

endmodule

// ----- sv/wtss_scan.sv -----
// ----------------------------------------------------------------------------
// wtss_scan - line scanner
// Byte window, position counter and first-match state; checks one candidate
// per byte and a final candidate at the line end, and forms the result.
// ----------------------------------------------------------------------------
module wtss_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  wtss_pkg::cfg_type             cfg,
   input  logic                          step,
   input  logic [7:0]                    text_byte,
   input  logic [wtss_pkg::POS_W-1:0]    start_offset,
   input  logic                          line_end,
   output wtss_pkg::rsp_type             result
);
   import wtss_pkg::*;

   window_type       window_ff, window_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             seen_ff, seen_in;
   logic [POS_W-1:0] mpos_ff, mpos_in;

   logic             in_range;
   logic             hit_byte, hit_end;
   window_type       win_next;
   logic [CNT_W-1:0] pos_next;
   logic             seen_byte, seen_end;
   logic [POS_W-1:0] mpos_byte, mpos_end;

   always_comb begin
      in_range = pos_ff < CNT_W'(LINE_MAX);

      // candidate that ends just before this byte, with this byte as its right edge
      hit_byte  = in_range && !seen_ff && is_boundary(text_byte, cfg.nondelim) &&
                  cand_ok(window_ff, pos_ff, start_offset, cfg);
      seen_byte = seen_ff || hit_byte;
      mpos_byte = hit_byte ? POS_W'(pos_ff - CNT_W'(cfg.pattern_len)) : mpos_ff;

      win_next = in_range ? {window_ff[WIN_DEPTH-2:0], text_byte} : window_ff;
      pos_next = in_range ? pos_ff + CNT_W'(1) : pos_ff;

      // line end is a boundary: candidate ending on the last byte
      hit_end  = !seen_byte && cand_ok(win_next, pos_next, start_offset, cfg);
      seen_end = seen_byte || hit_end;
      mpos_end = hit_end ? POS_W'(pos_next - CNT_W'(cfg.pattern_len)) : mpos_byte;

      result = '0;
      if (CNT_W'(start_offset) >= pos_next) begin
         result.offset_error = 1'b1;
      end else if (seen_end) begin
         result.found       = 1'b1;
         result.match_begin = mpos_end;
         result.match_end   = mpos_end + POS_W'(cfg.pattern_len) - POS_W'(1);
      end

      window_in = window_ff;
      pos_in    = pos_ff;
      seen_in   = seen_ff;
      mpos_in   = mpos_ff;
      if (step) begin
         if (line_end) begin
            window_in = '0;
            pos_in    = '0;
            seen_in   = 1'b0;
            mpos_in   = '0;
         end else begin
            window_in = win_next;
            pos_in    = pos_next;
            seen_in   = seen_byte;
            mpos_in   = mpos_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
         seen_ff   <= 1'b0;
         mpos_ff   <= '0;
      end else begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
         seen_ff   <= seen_in;
         mpos_ff   <= mpos_in;
      end
   end

endmodule

// ----- sv/whole_token_string_search_top.sv -----
// ----------------------------------------------------------------------------
// whole_token_string_search_top - whole-token string search
// Streams one line of text a byte per item and reports the leftmost
// whole-token match of the configured pattern at the line end.
// ----------------------------------------------------------------------------
// One text byte is taken per clock cycle, back to back. Each item passes an
// input register, then window comparison against the pattern; the result of
// a line is then held in the output register for the rsp_ channel. Only items
// with line_end high give a result. The input side stalls only when a
// line_end item reaches the compare stage while the previous result is still
// waiting in the output register. The user writes configuration through the
// csr_ port only while no line is in flight; the block does not enforce this.
module whole_token_string_search_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  wtss_pkg::csr_index_type             csr_index,
   input  logic [wtss_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_text_byte,
   input  logic [wtss_pkg::POS_W-1:0]          req_start_offset,
   input  logic                                req_line_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [wtss_pkg::POS_W-1:0]          rsp_match_begin,
   output logic [wtss_pkg::POS_W-1:0]          rsp_match_end,
   output logic                                rsp_offset_error
);
   import wtss_pkg::*;

   cfg_type          cfg;
   rsp_type          result;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic [POS_W-1:0] in_start_ff;
   logic             in_last_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;
   logic             advance;
   logic             req_take;

   wtss_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   wtss_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step         (advance),
      .text_byte    (in_byte_ff),
      .start_offset (in_start_ff),
      .line_end     (in_last_ff),
      .result       (result)
   );

   always_comb begin
      // a non-final item never needs the output register
      advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || advance;
      req_take  = req_valid && req_ready;

      in_valid_in = in_valid_ff;
      if (req_take)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_text_byte;
         in_start_ff <= req_start_offset;
         in_last_ff  <= req_line_end;
      end
      if (advance && in_last_ff)
         rsp_data_ff <= result;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_data_ff.found;
   assign rsp_match_begin  = rsp_data_ff.match_begin;
   assign rsp_match_end    = rsp_data_ff.match_end;
   assign rsp_offset_error = rsp_data_ff.offset_error;

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - whole-token string search
// Streams lines of text through the block under random valid/ready gaps and
// checks each line result against a cycle-free software copy of the search.
// Covers every register, case folding, delimiter masks, start offsets
// that move within a line, offset errors and a full-length pattern in a long
// line.
// ----------------------------------------------------------------------------
module testbench;
   import wtss_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 600;

   typedef struct {
      logic [7:0]       ch;
      logic [POS_W-1:0] start;
      logic             last;
   } text_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   csr_index_type         csr_index = REG_PATTERN_LOW;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_text_byte = '0;
   logic [POS_W-1:0]      req_start_offset = '0;
   logic                  req_line_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_found;
   logic [POS_W-1:0]      rsp_match_begin;
   logic [POS_W-1:0]      rsp_match_end;
   logic                  rsp_offset_error;

   whole_token_string_search_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_start_offset (req_start_offset),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_begin  (rsp_match_begin),
      .rsp_match_end    (rsp_match_end),
      .rsp_offset_error (rsp_offset_error)
   );

   always #5 clock = ~clock;

   // search settings as the block should hold them
   logic [63:0]  pat_lo = '0;
   logic [63:0]  pat_hi = '0;
   logic [4:0]   pat_len_reg = 5'd1;
   logic         fold_en = 1'b0;
   logic [255:0] tok_mask = '0;

   // per-line search state
   logic [7:0]   recent [0:PATTERN_MAX];
   int           line_pos = 0;
   bit           hit_seen = 0;
   int           hit_at = 0;

   text_item_type text_queue [$];
   rsp_type       report_queue [$];

   int send_wait = 0;
   bit send_burst = 0;
   int recv_wait = 0;
   int recv_hold = 0;
   bit recv_burst = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int results_seen = 0;
   int lines_queued = 0;
   int bytes_queued = 0;
   int reports_found = 0;
   int reports_error = 0;
   int settings_used = 0;

   initial begin
      for (int k = 0; k <= PATTERN_MAX; k++)
         recent[k] = 8'h00;
   end

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (fold_en && c >= 8'h61 && c <= 8'h7a)
         return c - 8'h20;
      return c;
   endfunction

   function automatic logic breaks_token(input logic [7:0] c);
      if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
          (c >= 8'h61 && c <= 8'h7a))
         return 1'b0;
      return !tok_mask[c];
   endfunction

   function automatic int pattern_span();
      int n;
      n = pat_len_reg;
      if (n < 1) n = 1;
      if (n > PATTERN_MAX) n = PATTERN_MAX;
      return n;
   endfunction

   // n pattern bytes sitting just before position endp, recent[0] at endp-1
   function automatic logic token_ends_at(input int endp, input int n, input int start);
      logic [127:0] pat_bits;
      int first_pos;
      pat_bits = {pat_hi, pat_lo};
      if (endp < n) return 1'b0;
      first_pos = endp - n;
      if (first_pos < start) return 1'b0;
      for (int j = 0; j < n; j++)
         if (fold_case(recent[n-1-j]) != fold_case(pat_bits[8*j +: 8]))
            return 1'b0;
      if (first_pos != 0 && !breaks_token(recent[n]))
         return 1'b0;
      return 1'b1;
   endfunction

   function automatic void search_step(input logic [7:0] ch, input logic [POS_W-1:0] start,
                                       input logic last);
      rsp_type r;
      int n;
      n = pattern_span();
      if (line_pos < LINE_MAX) begin
         if (!hit_seen && breaks_token(ch) && token_ends_at(line_pos, n, start)) begin
            hit_seen = 1;
            hit_at = line_pos - n;
         end
         for (int k = PATTERN_MAX; k > 0; k--)
            recent[k] = recent[k-1];
         recent[0] = ch;
         line_pos++;
      end
      if (last) begin
         if (!hit_seen && token_ends_at(line_pos, n, start)) begin
            hit_seen = 1;
            hit_at = line_pos - n;
         end
         r.found = 1'b0;
         r.match_begin = '0;
         r.match_end = '0;
         r.offset_error = 1'b0;
         if (int'(start) >= line_pos) begin
            r.offset_error = 1'b1;
            reports_error++;
         end else if (hit_seen) begin
            r.found = 1'b1;
            r.match_begin = POS_W'(hit_at);
            r.match_end = POS_W'(hit_at + n - 1);
            reports_found++;
         end
         report_queue.push_back(r);
         for (int k = 0; k <= PATTERN_MAX; k++)
            recent[k] = 8'h00;
         line_pos = 0;
         hit_seen = 0;
         hit_at = 0;
      end
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin : drive_proc
      text_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            search_step(req_text_byte, req_start_offset, req_line_end);
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (text_queue.size() > 0) begin
               nxt = text_queue.pop_front();
               req_valid <= 1'b1;
               req_text_byte <= nxt.ch;
               req_start_offset <= nxt.start;
               req_line_end <= nxt.last;
               if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
               send_wait = send_burst ? 0 : $urandom_range(0, 11);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (report_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: found=%0d begin=%0d end=%0d err=%0d",
                           rsp_found, rsp_match_begin, rsp_match_end, rsp_offset_error);
            end else begin
               want = report_queue.pop_front();
               if (rsp_found !== want.found || rsp_match_begin !== want.match_begin ||
                   rsp_match_end !== want.match_end ||
                   rsp_offset_error !== want.offset_error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d mismatch: expected found=%0d begin=%0d end=%0d ",
                              results_seen, want.found, want.match_begin, want.match_end,
                              "err=%0d, got found=%0d begin=%0d end=%0d err=%0d",
                              want.offset_error, rsp_found, rsp_match_begin, rsp_match_end,
                              rsp_offset_error);
               end
            end
            if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
            recv_wait = recv_burst ? 0 : $urandom_range(0, 11);
            // one long hold-off so the block backs up into its input
            if (results_seen == 40) recv_hold = HOLD_CYCLES;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without progress", idle_cycles);
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic push_item(input logic [7:0] ch, input int start, input logic last);
      text_item_type it;
      it.ch = ch;
      it.start = POS_W'(start);
      it.last = last;
      text_queue.push_back(it);
      bytes_queued++;
      if (last) lines_queued++;
   endtask

   task automatic push_text(input string s, input int start);
      for (int k = 0; k < s.len(); k++)
         push_item(s[k], start, k == s.len() - 1);
   endtask

   // sample between edges so the driver's and monitor's updates have settled
   task automatic wait_idle();
      while (text_queue.size() != 0 || req_valid || report_queue.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_reg(input csr_index_type idx, input logic [63:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      case (idx)
         REG_PATTERN_LOW:  pat_lo = val;
         REG_PATTERN_HIGH: pat_hi = val;
         REG_PATTERN_LEN:  pat_len_reg = val[4:0];
         REG_CASE_FOLD:    fold_en = val[0];
         REG_NONDELIM_0:   tok_mask[63:0] = val;
         REG_NONDELIM_1:   tok_mask[127:64] = val;
         REG_NONDELIM_2:   tok_mask[191:128] = val;
         REG_NONDELIM_3:   tok_mask[255:192] = val;
      endcase
   endtask

   task automatic configure(input logic [63:0] lo, input logic [63:0] hi, input logic [63:0] len,
                            input logic [63:0] fold, input logic [255:0] mask);
      wait_idle();
      set_reg(REG_PATTERN_LOW, lo);
      set_reg(REG_PATTERN_HIGH, hi);
      set_reg(REG_PATTERN_LEN, len);
      set_reg(REG_CASE_FOLD, fold);
      set_reg(REG_NONDELIM_0, mask[63:0]);
      set_reg(REG_NONDELIM_1, mask[127:64]);
      set_reg(REG_NONDELIM_2, mask[191:128]);
      set_reg(REG_NONDELIM_3, mask[255:192]);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [7:0] any_alnum();
      int r;
      r = $urandom_range(0, 61);
      if (r < 10) return 8'h30 + 8'(r);
      if (r < 36) return 8'h41 + 8'(r - 10);
      return 8'h61 + 8'(r - 36);
   endfunction

   function automatic logic [7:0] flip_case(input logic [7:0] c);
      if ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a))
         return c ^ 8'h20;
      return c;
   endfunction

   function automatic logic [63:0] random_mask();
      case ($urandom_range(0, 5))
         0, 1:    return '0;
         2:       return '1;
         3:       return {$urandom, $urandom};
         default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      endcase
   endfunction

   // one line mixing pattern copies (whole, cut short, case flipped) with filler
   task automatic queue_random_line();
      logic [7:0]   line_bytes [$];
      logic [127:0] pat_bits;
      logic [7:0]   ch;
      string        seps;
      int           len, n, pick, cut, start;
      bit           wobble;
      seps = " ,.-_;";
      pat_bits = {pat_hi, pat_lo};
      n = pattern_span();
      pick = $urandom_range(0, 9);
      if (pick < 2) len = $urandom_range(1, 3);
      else if (pick < 9) len = $urandom_range(4, 24);
      else len = $urandom_range(25, 80);
      while (line_bytes.size() < len) begin
         pick = $urandom_range(0, 11);
         if (pick < 4) begin
            cut = (pick == 0) ? $urandom_range(1, n) : n;
            for (int j = 0; j < cut; j++) begin
               ch = pat_bits[8*j +: 8];
               if ($urandom_range(0, 3) == 0) ch = flip_case(ch);
               line_bytes.push_back(ch);
            end
         end else if (pick < 7) begin
            line_bytes.push_back(seps[$urandom_range(0, seps.len() - 1)]);
         end else if (pick < 10) begin
            line_bytes.push_back(any_alnum());
         end else begin
            line_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) start = 0;
      else if (pick < 8) start = $urandom_range(0, len);
      else start = $urandom_range(0, 4095);
      wobble = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < len; k++)
         push_item(line_bytes[k], wobble ? $urandom_range(0, len) : start, k == len - 1);
   endtask

   initial begin
      logic [127:0] pat;
      logic [63:0]  len_data, fold_data;
      logic [255:0] mask;
      int           len, phase_start;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // pattern "AB", folding on, default delimiters
      configure(64'h4241, 64'h0, 64'd2, 64'd1, '0);
      push_text("ab", 0);        // whole line, folded
      push_text(" ab", 1);       // boundary byte lies before the start offset
      push_text("xab", 1);       // left neighbor is a token character
      push_text("ab", 2);        // offset equal to line length
      push_text("a", 4095);      // largest offset
      // start offset moves from byte to byte within the line
      push_item("a", 4, 1'b0);
      push_item("b", 4, 1'b0);
      push_item(" ", 0, 1'b0);
      push_item("a", 4, 1'b0);
      push_item("b", 0, 1'b1);

      // zero length counts as one; 0xFF made a token character, 0x00 a delimiter
      configure(64'hFF, 64'h0, 64'd0, 64'd0, {64'h8000_0000_0000_0000, 192'h0});
      push_item(8'h00, 0, 1'b0);
      push_item(8'hFF, 0, 1'b0);
      push_item(8'h00, 0, 1'b1);
      push_item(8'hFF, 0, 1'b0);
      push_item(8'hFF, 0, 1'b1);

      // long line: 16-byte pattern between two spaces near the end, random tail
      for (int j = 0; j < 16; j++)
         pat[8*j +: 8] = 8'h41 + 8'($urandom_range(0, 25));
      configure(pat[63:0], pat[127:64], 64'd31, 64'd0, '0);
      for (int k = 0; k < 100; k++) begin
         if (k >= 80 && k < 96) push_item(pat[8*(k-80) +: 8], 60, 1'b0);
         else if (k == 79 || k == 96 || (k < 96 && $urandom_range(0, 4) == 0))
            push_item(" ", 60, 1'b0);
         else if (k < 96) push_item(8'h61 + 8'($urandom_range(0, 25)), 60, 1'b0);
         else push_item(8'($urandom_range(0, 255)), 60, k == 99);
      end
      push_text("x", 0);

      // random settings, each followed by a batch of lines
      for (int ph = 0; ph < 10; ph++) begin
         for (int j = 0; j < 16; j++)
            pat[8*j +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                         : any_alnum();
         case (ph % 6)
            0:       len = 1;
            1:       len = 16;
            2:       len = 0;
            3:       len = $urandom_range(17, 31);
            default: len = $urandom_range(2, 6);
         endcase
         len_data = 64'(len);
         fold_data = 64'($urandom_range(0, 1));
         if (ph % 2) begin
            len_data[63:5] = 59'({$urandom, $urandom});
            fold_data[63:1] = 63'({$urandom, $urandom});
         end
         if (ph == 4) mask = '1;
         else mask = {random_mask(), random_mask(), random_mask(), random_mask()};
         configure(pat[63:0], pat[127:64], len_data, fold_data, mask);
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < 105)
            queue_random_line();
      end

      wait_idle();
      repeat (10) @(posedge clock);
      $display("sent %0d lines (%0d bytes) under %0d register settings",
               lines_queued, bytes_queued, settings_used);
      $display("checked %0d results: %0d matches, %0d offset errors, %0d mismatches",
               results_seen, reports_found, reports_error, mismatches);
      if (mismatches == 0 && report_queue.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
